// ----- src/length_field_deframer_defines.svh -----
// Assertion macros for the length field deframer.
`ifndef LENGTH_FIELD_DEFRAMER_DEFINES_SVH
`define LENGTH_FIELD_DEFRAMER_DEFINES_SVH
`ifndef SYNTH
`define LFD_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lfd check failed");
`define LFD_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lfd check failed");
`else
`define LFD_ASSERT_IMP(label, ck, rn, ante, cons)
`define LFD_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// ----- src/lfd_pkg.sv -----
// Constants and types of the length field deframer.
`default_nettype none

package lfd_pkg;

    // width of the frame byte counter
    localparam int FRAME_COUNT_BITS = 24;
    // wide enough for any frame total, signed
    localparam int TOT_W            = 35;
    // largest field end: offset 255 plus four bytes, minus one
    localparam int END_W            = 9;
    localparam int WIDE_W           = ((FRAME_COUNT_BITS > END_W) ? FRAME_COUNT_BITS : END_W) + 1;

    localparam logic [TOT_W-1:0] COUNT_MAX = (TOT_W'(1) << FRAME_COUNT_BITS) - TOT_W'(1);
    localparam logic [END_W-1:0] MAX_FIELD_END = END_W'(258);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_OFFSET   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_SIZE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIG_ENDIAN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEN_INCL_HEADER = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LENGTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_ADJUST   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_SIZE  = 3'd6;

    localparam logic [2:0]  RST_LENGTH_SIZE    = 3'd2;
    localparam logic [7:0]  RST_HEADER_LENGTH  = 8'd2;
    localparam logic [23:0] RST_MAX_FRAME_SIZE = 24'd65536;

    localparam logic [2:0] SIZE_ONE  = 3'd1;
    localparam logic [2:0] SIZE_TWO  = 3'd2;
    localparam logic [2:0] SIZE_FOUR = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SIZE_ERR = 2'd1;
    localparam logic [1:0] STATUS_CFG_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_start;
        logic       frame_last;
        logic [1:0] status;
    } lfd_result_t;

endpackage

`default_nettype wire

// ----- src/length_field_deframer.sv -----
// Length field deframer: marks frame boundaries in a byte stream.
//
//  channel | signals                               | dir | word
//  --------+---------------------------------------+-----+---------------------------
//  in      | in_valid, in_stall, data_byte         | in  | one stream byte
//  out     | out_valid, out_stall, out_byte, ...   | out | byte with marks and status
//  cfg     | cfg_write_en, cfg_index, cfg_data     | in  | one register write
//
//  One byte per cycle while in_stall is low; a taken byte's result is registered in the
//  output register, or in the skid register if the output stalls. The frame state
//  updates in the same cycle a byte is taken. The skid register holds one result;
//  in_stall is that skid register being full, so the input stalls once a result is parked there.
//  rst_n clears the frame state, the valid flags and the configuration registers to their reset values.
`default_nettype none
`include "length_field_deframer_defines.svh"

module length_field_deframer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        data_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [7:0]                             out_byte,
    output logic                                   frame_start,
    output logic                                   frame_last,
    output logic [1:0]                             status,
    input  wire logic                              cfg_write_en,
    input  wire logic [lfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = lfd_pkg::FRAME_COUNT_BITS;
    localparam int TW = lfd_pkg::TOT_W;
    localparam int EW = lfd_pkg::END_W;
    localparam int WW = lfd_pkg::WIDE_W;

    // configuration registers
    logic [7:0]  length_offset_reg;
    logic [2:0]  length_size_reg;
    logic        big_endian_reg;
    logic        length_includes_header_reg;
    logic [7:0]  header_length_reg;
    logic [15:0] length_adjust_reg;
    logic [23:0] max_frame_size_reg;

    // frame state
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [31:0]   length_value_reg, length_value_next;
    logic [CW-1:0] frame_total_reg, frame_total_next;
    logic          total_known_reg, total_known_next;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    lfd_pkg::lfd_result_t out_reg, out_next;
    lfd_pkg::lfd_result_t skid_reg, skid_next;
    lfd_pkg::lfd_result_t res;

    logic          accept;
    logic          out_load;
    logic [EW-1:0] field_end;
    logic [WW-1:0] pos_wide;
    logic [WW-1:0] end_wide;
    logic [WW-1:0] off_wide;
    logic [31:0]   len_base;
    logic [31:0]   len_acc;
    logic [1:0]    byte_sel;
    logic [TW-1:0] total;
    logic [TW-1:0] limit;
    logic [TW-1:0] pos_p1;
    logic          total_bad;
    logic          size_ok;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;

    assign field_end = EW'(length_offset_reg) + EW'(length_size_reg) - EW'(1);
    assign pos_wide  = WW'(byte_count_reg);
    assign end_wide  = WW'(field_end);
    assign off_wide  = WW'(length_offset_reg);
    assign byte_sel  = byte_count_reg[1:0] - length_offset_reg[1:0];
    assign pos_p1    = TW'(byte_count_reg) + TW'(1);

    // gather the length field bytes
    always_comb
    begin
        len_base = (byte_count_reg == '0) ? 32'd0 : length_value_reg;
        len_acc  = len_base;
        if (pos_wide >= off_wide)
        begin
            if (big_endian_reg)
            begin
                len_acc = {len_base[23:0], data_byte};
            end
            else
            begin
                case (byte_sel)
                    2'd0:    len_acc = len_base | {24'd0, data_byte};
                    2'd1:    len_acc = len_base | {16'd0, data_byte, 8'd0};
                    2'd2:    len_acc = len_base | {8'd0, data_byte, 16'd0};
                    default: len_acc = len_base | {data_byte, 24'd0};
                endcase
            end
        end
    end

    // frame total and its range check
    always_comb
    begin
        total = TW'(len_acc) + {{(TW-16){length_adjust_reg[15]}}, length_adjust_reg};
        if (!length_includes_header_reg)
        begin
            total = total + TW'(header_length_reg);
        end
        limit = (TW'(max_frame_size_reg) > lfd_pkg::COUNT_MAX) ? lfd_pkg::COUNT_MAX
                                                                : TW'(max_frame_size_reg);
        total_bad = total[TW-1] || (total == '0) || (total > limit)
                    || (total < TW'(field_end) + TW'(1));
    end

    always_comb
    begin
        size_ok = length_size_reg inside {lfd_pkg::SIZE_ONE, lfd_pkg::SIZE_TWO,
                                          lfd_pkg::SIZE_FOUR};
    end

    // frame state machine
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        length_value_next = length_value_reg;
        frame_total_next  = frame_total_reg;
        total_known_next  = total_known_reg;
        res.out_byte      = data_byte;
        res.frame_start   = (byte_count_reg == '0);
        res.frame_last    = 1'b0;
        res.status        = lfd_pkg::STATUS_OK;

        if (total_known_reg)
        begin
            if (pos_p1 >= TW'(frame_total_reg))
            begin
                res.frame_last = 1'b1;
            end
        end
        else if (!size_ok)
        begin
            res.frame_last = 1'b1;
            res.status     = lfd_pkg::STATUS_CFG_ERR;
        end
        else if (pos_wide > end_wide)
        begin
            res.frame_last = 1'b1;
            res.status     = lfd_pkg::STATUS_SIZE_ERR;
        end
        else if (pos_wide == end_wide)
        begin
            if (total_bad)
            begin
                res.frame_last = 1'b1;
                res.status     = lfd_pkg::STATUS_SIZE_ERR;
            end
            else if (total == pos_p1)
            begin
                res.frame_last = 1'b1;
            end
        end
        else if (&byte_count_reg)
        begin
            res.frame_last = 1'b1;
            res.status     = lfd_pkg::STATUS_SIZE_ERR;
        end

        if (!total_known_reg && size_ok && pos_wide <= end_wide)
        begin
            length_value_next = len_acc;
        end

        if (res.frame_last)
        begin
            // drop the frame and hunt from the next byte
            byte_count_next   = '0;
            length_value_next = 32'd0;
            frame_total_next  = '0;
            total_known_next  = 1'b0;
        end
        else
        begin
            byte_count_next = byte_count_reg + CW'(1);
            if (!total_known_reg && pos_wide == end_wide)
            begin
                frame_total_next = total[CW-1:0];
                total_known_next = 1'b1;
            end
        end
    end

    // output register with one skid entry
    always_comb
    begin
        out_load        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_load)
        begin
            out_valid_next  = skid_valid_reg || accept;
            out_next        = skid_valid_reg ? skid_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_offset_reg          <= 8'd0;
            length_size_reg            <= lfd_pkg::RST_LENGTH_SIZE;
            big_endian_reg             <= 1'b1;
            length_includes_header_reg <= 1'b0;
            header_length_reg          <= lfd_pkg::RST_HEADER_LENGTH;
            length_adjust_reg          <= 16'd0;
            max_frame_size_reg         <= lfd_pkg::RST_MAX_FRAME_SIZE;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                lfd_pkg::CFG_LENGTH_OFFSET:   length_offset_reg          <= cfg_data[7:0];
                lfd_pkg::CFG_LENGTH_SIZE:     length_size_reg            <= cfg_data[2:0];
                lfd_pkg::CFG_BIG_ENDIAN:      big_endian_reg             <= cfg_data[0];
                lfd_pkg::CFG_LEN_INCL_HEADER: length_includes_header_reg <= cfg_data[0];
                lfd_pkg::CFG_HEADER_LENGTH:   header_length_reg          <= cfg_data[7:0];
                lfd_pkg::CFG_LENGTH_ADJUST:   length_adjust_reg          <= cfg_data[15:0];
                lfd_pkg::CFG_MAX_FRAME_SIZE:  max_frame_size_reg         <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            length_value_reg <= 32'd0;
            frame_total_reg  <= '0;
            total_known_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                byte_count_reg   <= byte_count_next;
                length_value_reg <= length_value_next;
                frame_total_reg  <= frame_total_next;
                total_known_reg  <= total_known_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_reg.out_byte;
    assign frame_start = out_reg.frame_start;
    assign frame_last  = out_reg.frame_last;
    assign status      = out_reg.status;

    `LFD_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `LFD_ASSERT_IMP(a_total_ahead, clk, rst_n, total_known_reg,
                    frame_total_reg > byte_count_reg)
    `LFD_ASSERT_IMP(a_hunt_bounded, clk, rst_n, !total_known_reg,
                    WW'(byte_count_reg) <= WW'(lfd_pkg::MAX_FIELD_END))
    `LFD_ASSERT_IMP(a_error_ends_frame, clk, rst_n,
                    out_valid && status != lfd_pkg::STATUS_OK, frame_last)
    `LFD_ASSERT_NEXT(a_last_restarts, clk, rst_n, accept && res.frame_last,
                     byte_count_reg == '0 && !total_known_reg)

endmodule

`default_nettype wire
